// ===== src/des_pkg.sv =====
// DES package: permutation tables, S-boxes and helper functions.
// Used by des_round and the top level des_block_cipher_ecb_cbc.
package des_pkg;

  localparam int Rounds = 16;
  localparam int RndW = 4;

  typedef logic [63:0] blk_t;
  typedef logic [55:0] cd_t;
  typedef logic [47:0] rkey_t;

  // Register indexes
  typedef enum logic [1:0] {
    REG_KEY   = 2'd0,
    REG_IV    = 2'd1,
    REG_CHAIN = 2'd2,
    REG_DEC   = 2'd3
  } reg_idx_t;

  localparam logic [6:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [6:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [5:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [5:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam logic [6:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [5:0] PC2_TAB [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  // Left rotation per round: 1 where set, else 2
  localparam logic [15:0] SHIFT_ONE = 16'b1000_0001_0000_0011;

  localparam logic [3:0] S_TAB [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic blk_t ip_perm(input blk_t v);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - IP_TAB[i])];
    return r;
  endfunction

  function automatic blk_t fp_perm(input blk_t v);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - FP_TAB[i])];
    return r;
  endfunction

  function automatic cd_t pc1_perm(input blk_t v);
    cd_t r;
    for (int i = 0; i < 56; i++) r[55-i] = v[6'(7'd64 - PC1_TAB[i])];
    return r;
  endfunction

  function automatic rkey_t pc2_perm(input cd_t v);
    rkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = v[6'd56 - PC2_TAB[i]];
    return r;
  endfunction

  // Rotate both 28-bit halves left by the schedule amount of a round
  function automatic cd_t cd_rot(input cd_t v, input logic one);
    logic [27:0] c, d;
    c = v[55:28];
    d = v[27:0];
    if (one) begin
      c = {c[26:0], c[27]};
      d = {d[26:0], d[27]};
    end else begin
      c = {c[25:0], c[27:26]};
      d = {d[25:0], d[27:26]};
    end
    return {c, d};
  endfunction

  // Rotate halves right (decrypt key walk)
  function automatic cd_t cd_rotr(input cd_t v, input logic one);
    logic [27:0] c, d;
    c = v[55:28];
    d = v[27:0];
    if (one) begin
      c = {c[0], c[27:1]};
      d = {d[0], d[27:1]};
    end else begin
      c = {c[1:0], c[27:2]};
      d = {d[1:0], d[27:2]};
    end
    return {c, d};
  endfunction

endpackage

// ===== src/des_round.sv =====
// DES round unit: one Feistel round (E, key mix, S-boxes, P).
// Depends on des_pkg.
module des_round (
  input  logic [31:0]        l_in,
  input  logic [31:0]        r_in,
  input  des_pkg::rkey_t     rkey,
  output logic [31:0]        l_out,
  output logic [31:0]        r_out
);
  import des_pkg::*;

  logic [47:0] e;
  logic [31:0] s;
  logic [31:0] f;

  // Expansion, key mix, substitution and P permutation
  always_comb begin
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r_in[5'(6'd32 - E_TAB[i])];
    e = e ^ rkey;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) f[31-i] = s[5'(6'd32 - P_TAB[i])];
  end

  assign l_out = r_in;
  assign r_out = l_in ^ f;
endmodule

// ===== src/des_block_cipher_ecb_cbc.sv =====
// DES ECB/CBC top level: APB config, stream in/out, round sequencer.
// Depends on des_pkg and des_round.
//
// One 64-bit block is accepted on s_tvalid/s_tready; it runs through 16
// rounds of a single shared round unit, one round per clock, with round keys
// generated on the fly by rotating the PC1 key halves (left for encrypt,
// right for decrypt). The result is presented when the last round is done
// (the last round edge also loads the output register). After the result is
// taken the unit returns to IDLE before it accepts the next block, so blocks
// never overlap. Registers: 0x00 key, 0x08 IV, 0x10 chain mode, 0x18 decrypt
// mode; any write reloads the chain from IV.
module des_block_cipher_ecb_cbc (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // data_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // result_block
);
  import des_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t       state;
  logic [RndW-1:0] rnd;
  blk_t         cipher_key, init_vector, chain_value, in_block;
  logic         chain_mode, decrypt_mode;
  cd_t          cd;
  logic [31:0]  l, r, l_nx, r_nx;
  blk_t         result;
  cd_t          cd_key, cd_used;
  blk_t         pre, res_raw;
  logic         wr;
  logic [1:0]   ridx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[4:3];

  // Register read back
  always_comb begin
    unique case (ridx)
      REG_KEY:   prdata = cipher_key;
      REG_IV:    prdata = init_vector;
      REG_CHAIN: prdata = {63'd0, chain_mode};
      REG_DEC:   prdata = {63'd0, decrypt_mode};
      default:   prdata = '0;
    endcase
  end

  // Round key for the current round: encrypt rotates before use,
  // decrypt uses the current value (first key equals PC1 output).
  assign cd_key = pc1_perm(cipher_key);
  assign cd_used = decrypt_mode ? cd : cd_rot(cd, SHIFT_ONE[rnd]);

  des_round u_round (
    .l_in  (l),
    .r_in  (r),
    .rkey  (pc2_perm(cd_used)),
    .l_out (l_nx),
    .r_out (r_nx)
  );

  assign pre = ip_perm(s_tdata ^ ((chain_mode && !decrypt_mode) ? chain_value : '0));
  assign res_raw = fp_perm({r_nx, l_nx});

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == DONE);
  assign m_tdata = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rnd <= '0;
      cipher_key <= '0;
      init_vector <= '0;
      chain_mode <= 1'b0;
      decrypt_mode <= 1'b0;
      chain_value <= '0;
    end else begin
      // Config writes (the user must write only while idle; the block does not enforce it)
      if (wr) begin
        unique case (ridx)
          REG_KEY:   cipher_key <= pwdata;
          REG_IV:    init_vector <= pwdata;
          REG_CHAIN: chain_mode <= pwdata[0];
          REG_DEC:   decrypt_mode <= pwdata[0];
          default:   ;
        endcase
        chain_value <= (ridx == REG_IV) ? pwdata : init_vector;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            {l, r} <= pre;
            cd <= cd_key;
            in_block <= s_tdata;
            rnd <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          l <= l_nx;
          r <= r_nx;
          // Decrypt steps back through the schedule: round i undoes shift 15-i
          cd <= decrypt_mode ? cd_rotr(cd, SHIFT_ONE[~rnd]) : cd_used;
          rnd <= rnd + 1'b1;
          if (rnd == RndW'(Rounds - 1)) begin
            if (chain_mode && decrypt_mode) begin
              result <= res_raw ^ chain_value;
              chain_value <= in_block;
            end else begin
              result <= res_raw;
              if (chain_mode) chain_value <= res_raw;
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (m_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
